// ===== rtl/slet_pkg.sv =====
// Shared types and constants of the serial line editor and tokenizer.
package slet_pkg;

    // Width of one stored line character
    localparam int unsigned LS_W = 7;

    // Terminal character codes
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_GT    = 8'h3e;
    localparam logic [7:0] CH_TILDE = 8'h7e;
    localparam logic [7:0] CH_DEL   = 8'h7f;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_ECHO  = 2'd0,
        KIND_TOKEN = 2'd1,
        KIND_DONE  = 2'd2
    } t_kind;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_ECHO,
        S_RUB,
        S_CRLF,
        S_SCAN_RD,
        S_SCAN_EV,
        S_DONE,
        S_PROMPT
    } t_state;

    // Byte classification
    typedef struct packed {
        logic is_cr;
        logic is_lf;
        logic is_bs;
        logic is_print;
        logic is_sep;
    } t_class;

    // One result beat handed to the output register
    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        logic [2:0] tidx;
        logic       tlast;
        logic [3:0] argc;
        logic       last;
    } t_result;

    // Byte of the rubout sequence: backspace, space, backspace
    function automatic logic [7:0] rub_byte(input logic [1:0] step);
        logic [7:0] b;
        b = (step == 2'd1) ? CH_SP : CH_BS;
        return b;
    endfunction

endpackage

// ===== rtl/slet_line_ram.sv =====
// Line store: one write port, one read port with registered read data.
module slet_line_ram #(
    parameter int unsigned DEPTH = 32,
    parameter int unsigned AW    = 5
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [AW-1:0]            i_wr_addr,
    input  logic [slet_pkg::LS_W-1:0] i_wr_data,
    input  logic                     i_rd_en,
    input  logic [AW-1:0]            i_rd_addr,
    output logic [slet_pkg::LS_W-1:0] o_rd_data
);

    logic [slet_pkg::LS_W-1:0] r_mem [DEPTH];
    logic [slet_pkg::LS_W-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, data holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/slet_class.sv =====
// Shared byte compare unit: classifies incoming bytes and stored characters.
module slet_class (
    input  logic [7:0]       i_byte,
    output slet_pkg::t_class o_cls
);

    always_comb begin
        o_cls.is_cr    = (i_byte == slet_pkg::CH_CR);
        o_cls.is_lf    = (i_byte == slet_pkg::CH_LF);
        o_cls.is_bs    = (i_byte == slet_pkg::CH_BS) || (i_byte == slet_pkg::CH_DEL);
        o_cls.is_print = (i_byte >= slet_pkg::CH_SP) && (i_byte <= slet_pkg::CH_TILDE);
        o_cls.is_sep   = (i_byte == slet_pkg::CH_SP) || (i_byte == slet_pkg::CH_TAB);
    end

endmodule

// ===== rtl/slet_out_reg.sv =====
// Output register: holds one result beat for the master side.
module slet_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  slet_pkg::t_result i_res,
    input  logic              i_tready,
    output logic              o_free,
    output logic              o_tvalid,
    output logic [15:0]       o_tdata,
    output logic [1:0]        o_tuser,
    output logic              o_tlast
);

    logic              r_valid;
    slet_pkg::t_result r_res;

    assign o_free = !r_valid || i_tready;

    // Valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_push;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (o_free && i_push) begin
            r_res <= i_res;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = {r_res.argc, r_res.tlast, r_res.tidx, r_res.data};
    assign o_tuser  = r_res.kind;
    assign o_tlast  = r_res.last;

endmodule

// ===== rtl/serial_line_editor_tokenizer.sv =====
// Serial line editor and tokenizer with echo: top level and sequencer.
//
// One received byte is taken per beat on the slave side; s_axis_tready is high
// only while the sequencer is idle. A printable byte is accepted and echoed in one
// beat, a backspace in three rubout beats; a dropped byte gives no beat. At end of
// line the block sends CR LF, then the scan walks the line store one entry per
// cycle through its single read port and the shared compare unit, then it sends
// the done beat and the two prompt bytes. The scan rate holds only while the
// master side takes each beat at once; a held m_axis_tready stalls every beat.
// The line store needs no clearing after reset.
module serial_line_editor_tokenizer #(
    parameter int unsigned LINE_MAX = 32,
    parameter int unsigned MAX_ARGS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] data, [10:8] token_index,
                                        // [11] token_last, [15:12] arg_count
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast    // last
);

    localparam int unsigned AW = (LINE_MAX > 2) ? $clog2(LINE_MAX) : 1;
    localparam int unsigned CW = $clog2(MAX_ARGS + 2);
    localparam logic [AW-1:0] FILL_LIM = AW'(LINE_MAX - 1);
    localparam logic [CW-1:0] ARG_MAX  = CW'(MAX_ARGS);
    localparam logic [CW-1:0] ARG_OVER = CW'(MAX_ARGS + 1);

    slet_pkg::t_state          r_state, n_state;
    logic [AW-1:0]             r_fill, n_fill;
    logic                      r_cr_seen, n_cr_seen;
    logic [7:0]                r_byte, n_byte;
    logic [1:0]                r_step, n_step;
    logic [AW-1:0]             r_idx, n_idx;
    logic [CW-1:0]             r_argc, n_argc;
    logic                      r_have_cur, n_have_cur;
    logic [slet_pkg::LS_W-1:0] r_cur, n_cur;
    logic                      r_cur_keep, n_cur_keep;

    logic                      w_in_acc;
    logic [7:0]                w_cls_in;
    slet_pkg::t_class          w_cls;
    logic                      w_wr_en;
    logic                      w_rd_en;
    logic [AW-1:0]             w_rd_addr;
    logic [slet_pkg::LS_W-1:0] w_rd_data;
    logic                      w_push;
    slet_pkg::t_result         w_res;
    logic                      w_free;
    logic                      w_end;
    logic                      w_n_sep;
    logic                      w_emit;
    logic [CW-1:0]             w_argc_inc;
    logic [CW-1:0]             w_argc_sat;

    assign s_axis_tready = (r_state == slet_pkg::S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    // Compare unit input: received byte while idle, stored character otherwise
    assign w_cls_in = (r_state == slet_pkg::S_IDLE) ? s_axis_tdata : {1'b0, w_rd_data};

    slet_class u_class (
        .i_byte (w_cls_in),
        .o_cls  (w_cls)
    );

    slet_line_ram #(
        .DEPTH (LINE_MAX),
        .AW    (AW)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_fill),
        .i_wr_data (s_axis_tdata[slet_pkg::LS_W-1:0]),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    slet_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_res    (w_res),
        .i_tready (m_axis_tready),
        .o_free   (w_free),
        .o_tvalid (m_axis_tvalid),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser),
        .o_tlast  (m_axis_tlast)
    );

    // Scan helpers
    assign w_end      = (r_idx == r_fill);
    assign w_n_sep    = w_end || w_cls.is_sep;
    assign w_emit     = r_have_cur && r_cur_keep;
    assign w_argc_inc = (r_argc == ARG_OVER) ? r_argc : r_argc + CW'(1);
    assign w_argc_sat = (r_argc > ARG_MAX) ? ARG_MAX : r_argc;

    // State register and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= slet_pkg::S_IDLE;
            r_fill    <= '0;
            r_cr_seen <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_cr_seen <= n_cr_seen;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_byte     <= n_byte;
        r_step     <= n_step;
        r_idx      <= n_idx;
        r_argc     <= n_argc;
        r_have_cur <= n_have_cur;
        r_cur      <= n_cur;
        r_cur_keep <= n_cur_keep;
    end

    // Sequencer
    always_comb begin
        n_state    = r_state;
        n_fill     = r_fill;
        n_cr_seen  = r_cr_seen;
        n_byte     = r_byte;
        n_step     = r_step;
        n_idx      = r_idx;
        n_argc     = r_argc;
        n_have_cur = r_have_cur;
        n_cur      = r_cur;
        n_cur_keep = r_cur_keep;
        w_wr_en    = 1'b0;
        w_rd_en    = 1'b0;
        w_rd_addr  = r_idx;
        w_push     = 1'b0;
        w_res      = '{kind: slet_pkg::KIND_ECHO, data: '0, tidx: '0,
                       tlast: 1'b0, argc: '0, last: 1'b0};

        unique case (r_state)
            slet_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_byte = s_axis_tdata;
                    n_step = 2'd0;
                    if (r_cr_seen && w_cls.is_lf) begin
                        // LF right after CR is swallowed
                        n_cr_seen = 1'b0;
                    end else begin
                        n_cr_seen = w_cls.is_cr;
                        priority if (w_cls.is_cr || w_cls.is_lf) begin
                            n_state = slet_pkg::S_CRLF;
                        end else if (w_cls.is_bs) begin
                            if (r_fill != '0) begin
                                n_fill  = r_fill - AW'(1);
                                n_state = slet_pkg::S_RUB;
                            end
                        end else if (w_cls.is_print && (r_fill < FILL_LIM)) begin
                            w_wr_en = 1'b1;
                            n_fill  = r_fill + AW'(1);
                            n_state = slet_pkg::S_ECHO;
                        end
                    end
                end
            end

            slet_pkg::S_ECHO: begin
                if (w_free) begin
                    w_push     = 1'b1;
                    w_res.data = r_byte;
                    w_res.last = 1'b1;
                    n_state    = slet_pkg::S_IDLE;
                end
            end

            slet_pkg::S_RUB: begin
                if (w_free) begin
                    w_push     = 1'b1;
                    w_res.data = slet_pkg::rub_byte(r_step);
                    w_res.last = (r_step == 2'd2);
                    n_step     = r_step + 2'd1;
                    if (r_step == 2'd2) begin
                        n_state = slet_pkg::S_IDLE;
                    end
                end
            end

            slet_pkg::S_CRLF: begin
                if (w_free) begin
                    w_push     = 1'b1;
                    w_res.data = (r_step == 2'd0) ? slet_pkg::CH_CR : slet_pkg::CH_LF;
                    n_step     = r_step + 2'd1;
                    if (r_step == 2'd1) begin
                        n_idx      = '0;
                        n_argc     = '0;
                        n_have_cur = 1'b0;
                        n_cur_keep = 1'b0;
                        n_state    = slet_pkg::S_SCAN_RD;
                    end
                end
            end

            slet_pkg::S_SCAN_RD: begin
                // Prime the read of the first entry
                w_rd_en = 1'b1;
                n_state = slet_pkg::S_SCAN_EV;
            end

            slet_pkg::S_SCAN_EV: begin
                // Character at r_idx is on the read data; emit the one before it
                if (!w_emit || w_free) begin
                    if (w_emit) begin
                        w_push      = 1'b1;
                        w_res.kind  = slet_pkg::KIND_TOKEN;
                        w_res.data  = {1'b0, r_cur};
                        w_res.tidx  = 3'(r_argc - CW'(1));
                        w_res.tlast = w_n_sep;
                    end
                    if (!w_n_sep) begin
                        if (!r_have_cur) begin
                            n_argc     = w_argc_inc;
                            n_cur_keep = (w_argc_inc <= ARG_MAX);
                        end
                        n_cur      = w_rd_data;
                        n_have_cur = 1'b1;
                    end else begin
                        n_have_cur = 1'b0;
                    end
                    if (w_end) begin
                        n_state = slet_pkg::S_DONE;
                    end else begin
                        n_idx     = r_idx + AW'(1);
                        w_rd_en   = 1'b1;
                        w_rd_addr = r_idx + AW'(1);
                    end
                end
            end

            slet_pkg::S_DONE: begin
                if (w_free) begin
                    w_push     = 1'b1;
                    w_res.kind = slet_pkg::KIND_DONE;
                    w_res.argc = 4'(w_argc_sat);
                    n_fill     = '0;
                    n_step     = 2'd0;
                    n_state    = slet_pkg::S_PROMPT;
                end
            end

            slet_pkg::S_PROMPT: begin
                if (w_free) begin
                    w_push     = 1'b1;
                    w_res.data = (r_step == 2'd0) ? slet_pkg::CH_GT : slet_pkg::CH_SP;
                    w_res.last = (r_step == 2'd1);
                    n_step     = r_step + 2'd1;
                    if (r_step == 2'd1) begin
                        n_state = slet_pkg::S_IDLE;
                    end
                end
            end

            default: begin
                n_state = slet_pkg::S_IDLE;
            end
        endcase
    end

endmodule
